// File: sv/i2cfm_pkg.sv
// Shared types, codes and constants of the I2C memory transaction master.
`default_nettype none

package i2cfm_pkg;

  localparam int BUF_DEPTH   = 64;
  localparam int BUF_AW      = 6;
  localparam int LEN_W       = 7;
  localparam int ADDR_W      = 16;
  localparam int GAP_W       = 20;
  localparam int ATT_W       = 3;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  localparam logic [7:0]       DEV_WR        = 8'hA0;
  localparam logic [7:0]       DEV_RD        = 8'hA1;
  localparam logic [GAP_W-1:0] GAP_RESET     = 20'd50000;
  localparam logic [ATT_W-1:0] MAX_ATT_RESET = 3'd3;
  localparam logic [ATT_W-1:0] ATT_LIMIT     = 3'd7;

  // Bit positions of the result word.
  localparam int OUT_SCL_BIT    = 0;
  localparam int OUT_SDA_BIT    = 1;
  localparam int OUT_BUSY_BIT   = 2;
  localparam int OUT_DONE_BIT   = 3;
  localparam int OUT_FAILED_BIT = 4;
  localparam int OUT_RBYTE_LSB  = 5;
  localparam int OUT_ATT_LSB    = 13;

  typedef enum logic [2:0] {
    OP_TICK     = 3'd0,
    OP_LOAD     = 3'd1,
    OP_START_WR = 3'd2,
    OP_START_RD = 3'd3,
    OP_FETCH    = 3'd4
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDE_ADDR    = 2'd0,
    REG_RETRY_GAP    = 2'd1,
    REG_MAX_ATTEMPTS = 2'd2
  } cfg_reg_t;

endpackage : i2cfm_pkg

`default_nettype wire

// File: sv/i2c_fram_transaction_master.sv
// A word's result is held first in the stage-1 registers (buffer read), then in the output register.
// Throughput: one word per cycle while the output is not stalled; every op, including a bus tick,
// is taken back to back. The rate is set by the 64 x 8 buffer memory, which serves one load, fetch or
// bus byte transfer per word; a byte read for transmission is forwarded from its read register.
// Reset (rst_n low, synchronous): bus idle with both lines released, counters cleared,
// registers at their defaults; the buffer contents are undefined until written.
`default_nettype none

module i2c_fram_transaction_master (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // Fields from bit 0: sda_in, mem_addr[15:0], length[6:0], buf_index[5:0], buf_byte[7:0].
  input  wire logic [i2cfm_pkg::IN_TDATA_W-1:0]   in_tdata,
  // Fields from bit 0: op[2:0].
  input  wire logic [2:0]                         in_tuser,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // Fields from bit 0: scl, sda_out, busy_res, done_res, failed, read_byte[7:0],
  // attempts_used[2:0].
  output logic [i2cfm_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [i2cfm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [i2cfm_pkg::GAP_W-1:0]        cfg_data
);

  import i2cfm_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_GAP, PH_START, PH_RS_A, PH_RS_B, PH_TX_LO, PH_TX_HI, PH_ACK_LO,
    PH_ACK_HI, PH_RX_LO, PH_RX_HI, PH_MACK_LO, PH_MACK_HI, PH_STOP_A, PH_STOP_B
  } phase_t;

  typedef enum logic [2:0] {
    SG_DEV, SG_AHI, SG_ALO, SG_RDEV, SG_WDATA
  } stage_t;

  logic               in_sda;
  logic [ADDR_W-1:0]  in_addr;
  logic [LEN_W-1:0]   in_len;
  logic [BUF_AW-1:0]  in_idx;
  logic [7:0]         in_byte;

  assign in_sda  = in_tdata[0];
  assign in_addr = in_tdata[16:1];
  assign in_len  = in_tdata[23:17];
  assign in_idx  = in_tdata[29:24];
  assign in_byte = in_tdata[37:30];

  logic               wide_r;
  logic [GAP_W-1:0]   retry_gap_r;
  logic [ATT_W-1:0]   max_att_r;

  phase_t             phase_r, phase_nxt;
  stage_t             stage_r, stage_nxt;
  logic [3:0]         bit_r, bit_nxt;
  logic [LEN_W-1:0]   byte_r, byte_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [LEN_W-1:0]   len_r, len_nxt;
  logic               is_read_r, is_read_nxt;
  logic [ATT_W-1:0]   att_r, att_nxt;
  logic [GAP_W-1:0]   gap_r, gap_nxt;
  logic               err_r, err_nxt;
  logic               scl_r, scl_nxt;
  logic               sda_r, sda_nxt;
  logic               pend_r, pend_nxt;
  logic               done_r, done_nxt;
  logic               fetch_r, fetch_nxt;
  logic               s1_vld_r;
  logic               out_vld_r;
  logic [OUT_TDATA_W-1:0] out_data_r;

  logic [7:0]         mem [BUF_DEPTH];
  logic [7:0]         rdata_r;
  logic               mem_we;
  logic [BUF_AW-1:0]  mem_waddr;
  logic [7:0]         mem_wdata;
  logic [BUF_AW-1:0]  mem_raddr;

  logic               in_accept;
  logic               s1_move;
  logic [7:0]         shift_eff;
  logic               sda_eff;
  logic               enter_now;
  phase_t             enter_ph;
  logic [7:0]         rx_shift;
  logic [LEN_W-1:0]   clamp_len;
  logic [7:0]         dev_byte;
  logic [OUT_TDATA_W-1:0] s1_word;

  assign s1_move    = s1_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !s1_vld_r || s1_move;
  assign in_accept  = in_tvalid && in_tready;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign cfg_ready  = 1'b1;

  assign shift_eff = pend_r ? rdata_r : shift_r;
  assign sda_eff   = pend_r ? rdata_r[7] : sda_r;
  assign rx_shift  = {shift_eff[6:0], in_sda};
  assign dev_byte  = wide_r ? DEV_WR : (DEV_WR | {4'b0000, addr_r[10:8], 1'b0});

  always_comb begin
    clamp_len = in_len;
    if (in_len == '0) begin
      clamp_len = LEN_W'(1);
    end else if (in_len > LEN_W'(BUF_DEPTH)) begin
      clamp_len = LEN_W'(BUF_DEPTH);
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    stage_nxt   = stage_r;
    bit_nxt     = bit_r;
    byte_nxt    = byte_r;
    shift_nxt   = shift_eff;
    addr_nxt    = addr_r;
    len_nxt     = len_r;
    is_read_nxt = is_read_r;
    att_nxt     = att_r;
    gap_nxt     = gap_r;
    err_nxt     = err_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_eff;
    pend_nxt    = 1'b0;
    done_nxt    = 1'b0;
    fetch_nxt   = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = in_idx;
    mem_wdata   = in_byte;
    mem_raddr   = in_idx;
    enter_now   = 1'b0;
    enter_ph    = phase_r;

    unique case (op_t'(in_tuser))
      OP_TICK: begin
        enter_now = 1'b1;
        unique case (phase_r)
          PH_IDLE: enter_ph = PH_IDLE;
          PH_GAP: begin
            if (gap_r != '0) begin
              gap_nxt  = gap_r - GAP_W'(1);
              enter_ph = PH_GAP;
            end else begin
              if (att_r < ATT_LIMIT) begin
                att_nxt = att_r + ATT_W'(1);
              end
              err_nxt   = 1'b0;
              stage_nxt = SG_DEV;
              shift_nxt = dev_byte;
              bit_nxt   = '0;
              enter_ph  = PH_START;
            end
          end
          PH_START: enter_ph = PH_TX_LO;
          PH_RS_A:  enter_ph = PH_RS_B;
          PH_RS_B: begin
            stage_nxt = SG_RDEV;
            shift_nxt = DEV_RD;
            bit_nxt   = '0;
            enter_ph  = PH_START;
          end
          PH_TX_LO: enter_ph = PH_TX_HI;
          PH_TX_HI: begin
            shift_nxt = {shift_eff[6:0], 1'b0};
            bit_nxt   = bit_r + 4'd1;
            enter_ph  = (bit_nxt >= 4'd8) ? PH_ACK_LO : PH_TX_LO;
          end
          PH_ACK_LO: enter_ph = PH_ACK_HI;
          PH_ACK_HI: begin
            if (in_sda) begin
              err_nxt = 1'b1;
            end
            unique case (stage_r)
              SG_DEV: begin
                bit_nxt  = '0;
                enter_ph = PH_TX_LO;
                if (wide_r) begin
                  stage_nxt = SG_AHI;
                  shift_nxt = addr_r[15:8];
                end else begin
                  stage_nxt = SG_ALO;
                  shift_nxt = addr_r[7:0];
                end
              end
              SG_AHI: begin
                stage_nxt = SG_ALO;
                shift_nxt = addr_r[7:0];
                bit_nxt   = '0;
                enter_ph  = PH_TX_LO;
              end
              SG_ALO: begin
                byte_nxt = '0;
                if (is_read_r) begin
                  enter_ph = PH_RS_A;
                end else begin
                  stage_nxt = SG_WDATA;
                  mem_raddr = '0;
                  pend_nxt  = 1'b1;
                  bit_nxt   = '0;
                  enter_ph  = PH_TX_LO;
                end
              end
              SG_RDEV: begin
                byte_nxt  = '0;
                bit_nxt   = '0;
                shift_nxt = '0;
                enter_ph  = PH_RX_LO;
              end
              default: begin
                if (in_sda) begin
                  enter_ph = PH_STOP_A;
                end else begin
                  byte_nxt = byte_r + LEN_W'(1);
                  if (byte_nxt >= len_r) begin
                    enter_ph = PH_STOP_A;
                  end else begin
                    mem_raddr = byte_nxt[BUF_AW-1:0];
                    pend_nxt  = 1'b1;
                    bit_nxt   = '0;
                    enter_ph  = PH_TX_LO;
                  end
                end
              end
            endcase
          end
          PH_RX_LO: enter_ph = PH_RX_HI;
          PH_RX_HI: begin
            shift_nxt = rx_shift;
            bit_nxt   = bit_r + 4'd1;
            if (bit_nxt >= 4'd8) begin
              mem_we    = 1'b1;
              mem_waddr = byte_r[BUF_AW-1:0];
              mem_wdata = rx_shift;
              enter_ph  = PH_MACK_LO;
            end else begin
              enter_ph = PH_RX_LO;
            end
          end
          PH_MACK_LO: enter_ph = PH_MACK_HI;
          PH_MACK_HI: begin
            byte_nxt = byte_r + LEN_W'(1);
            if (byte_nxt >= len_r) begin
              enter_ph = PH_STOP_A;
            end else begin
              bit_nxt   = '0;
              shift_nxt = '0;
              enter_ph  = PH_RX_LO;
            end
          end
          PH_STOP_A: enter_ph = PH_STOP_B;
          PH_STOP_B: begin
            if (err_r && (att_r < max_att_r)) begin
              gap_nxt  = retry_gap_r;
              enter_ph = PH_GAP;
            end else begin
              done_nxt = 1'b1;
              enter_ph = PH_IDLE;
            end
          end
          default: enter_ph = PH_IDLE;
        endcase
      end
      OP_LOAD: mem_we = 1'b1;
      OP_START_WR, OP_START_RD: begin
        if (phase_r == PH_IDLE) begin
          addr_nxt    = in_addr;
          len_nxt     = clamp_len;
          is_read_nxt = (op_t'(in_tuser) == OP_START_RD);
          att_nxt     = '0;
          err_nxt     = 1'b0;
          gap_nxt     = '0;
          phase_nxt   = PH_GAP;
        end
      end
      OP_FETCH: fetch_nxt = 1'b1;
      default: ;
    endcase

    if (enter_now) begin
      phase_nxt = enter_ph;
      unique case (enter_ph) inside
        PH_START: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b0;
        end
        PH_RS_A, PH_ACK_LO, PH_RX_LO: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b1;
        end
        PH_TX_LO: begin
          scl_nxt = 1'b0;
          sda_nxt = shift_nxt[7];
        end
        PH_MACK_LO: begin
          scl_nxt = 1'b0;
          sda_nxt = ({1'b0, byte_nxt} + 8'd1) >= {1'b0, len_r};
        end
        PH_TX_HI, PH_ACK_HI, PH_RX_HI, PH_MACK_HI, PH_STOP_B: scl_nxt = 1'b1;
        PH_STOP_A: begin
          scl_nxt = 1'b0;
          sda_nxt = 1'b0;
        end
        default: begin
          scl_nxt = 1'b1;
          sda_nxt = 1'b1;
        end
      endcase
    end
  end

  always_comb begin
    s1_word                 = '0;
    s1_word[OUT_SCL_BIT]    = scl_r;
    s1_word[OUT_SDA_BIT]    = sda_eff;
    s1_word[OUT_BUSY_BIT]   = (phase_r != PH_IDLE);
    s1_word[OUT_DONE_BIT]   = done_r;
    s1_word[OUT_FAILED_BIT] = done_r & err_r;
    s1_word[OUT_RBYTE_LSB +: 8] = fetch_r ? rdata_r : 8'h00;
    s1_word[OUT_ATT_LSB +: ATT_W] = att_r;
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      if (mem_we) begin
        mem[mem_waddr] <= mem_wdata;
      end
      rdata_r <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wide_r      <= 1'b0;
      retry_gap_r <= GAP_RESET;
      max_att_r   <= MAX_ATT_RESET;
      phase_r     <= PH_IDLE;
      stage_r     <= SG_DEV;
      bit_r       <= '0;
      byte_r      <= '0;
      shift_r     <= '0;
      addr_r      <= '0;
      len_r       <= LEN_W'(1);
      is_read_r   <= 1'b0;
      att_r       <= '0;
      gap_r       <= '0;
      err_r       <= 1'b0;
      scl_r       <= 1'b1;
      sda_r       <= 1'b1;
      pend_r      <= 1'b0;
      done_r      <= 1'b0;
      fetch_r     <= 1'b0;
      s1_vld_r    <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_reg_t'(cfg_index))
          REG_WIDE_ADDR:    wide_r      <= cfg_data[0];
          REG_RETRY_GAP:    retry_gap_r <= cfg_data;
          REG_MAX_ATTEMPTS: max_att_r   <= cfg_data[ATT_W-1:0];
          default: ;
        endcase
      end
      if (in_accept) begin
        phase_r   <= phase_nxt;
        stage_r   <= stage_nxt;
        bit_r     <= bit_nxt;
        byte_r    <= byte_nxt;
        shift_r   <= shift_nxt;
        addr_r    <= addr_nxt;
        len_r     <= len_nxt;
        is_read_r <= is_read_nxt;
        att_r     <= att_nxt;
        gap_r     <= gap_nxt;
        err_r     <= err_nxt;
        scl_r     <= scl_nxt;
        sda_r     <= sda_nxt;
        pend_r    <= pend_nxt;
        done_r    <= done_nxt;
        fetch_r   <= fetch_nxt;
        s1_vld_r  <= 1'b1;
      end else if (s1_move) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_move) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_data_r <= s1_word;
    end
  end

endmodule : i2c_fram_transaction_master

`default_nettype wire

// File: sv/i2cfm_checker.sv
// Port-level checks of the I2C memory transaction master, bound to the top level.
`default_nettype none

module i2cfm_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [i2cfm_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  import i2cfm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result word changed or dropped while stalled.");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_DONE_BIT] |-> !out_tdata[OUT_BUSY_BIT])
    else $error("Transaction reported done while still busy.");

  a_failed_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_FAILED_BIT] |-> out_tdata[OUT_DONE_BIT])
    else $error("Failure flagged without done.");

  a_done_attempt: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_DONE_BIT] |-> out_tdata[OUT_ATT_LSB +: ATT_W] != '0)
    else $error("Transaction finished with no attempt counted.");

endmodule : i2cfm_checker

bind i2c_fram_transaction_master i2cfm_checker u_i2cfm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire
